/* hdl/swrc_pkg.sv */
package swrc_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd2000;
  localparam logic [3:0]  MAX_SENDS_RESET   = 4'd3;
  localparam logic [15:0] COOLDOWN_RESET    = 16'd5000;
  localparam logic [7:0]  DEBOUNCE_RESET    = 8'd20;

  localparam logic [31:0] ACK_WORD = 32'h41434B3A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACK_TIMEOUT = 2'd0,
    REG_MAX_SENDS   = 2'd1,
    REG_COOLDOWN    = 2'd2,
    REG_DEBOUNCE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        button_low;
    logic        msg_valid;
    logic [31:0] msg_head;
  } tick_t;

  typedef struct packed {
    logic       send_pulse;
    logic       gave_up;
    logic       ack_seen;
    logic       waiting;
    logic       cooling;
    logic [3:0] send_count;
  } result_t;

endpackage

/* hdl/stop_and_wait_retry_controller.sv */
// Stop-and-wait command sender with retries, stepped by one tick per transfer.
// Each transfer on the tick channel carries the button level and an optional
// received message head for one millisecond tick. Each tick produces exactly
// one transfer on the result channel: send, give-up and acknowledgment pulses
// plus the waiting and cooling flags and the send count after that tick.
// The configuration port writes the timeout, the send limit, the cooldown and
// the debounce length; it is meant to be written while no tick is in flight.
// An accepted tick's result is registered in the result register or skid stage.
// Throughput is one tick per cycle while tick_stall is low, set by the single
// register stage of the sender state, updated in the cycle a tick is accepted.
// A result register with a one-entry skid stage sits on the output, so a
// tick is still taken while one result waits; tick_stall is high exactly
// while the skid stage is full, which needs the result register to be full.
// Results leave in order and are never dropped while the receiver stalls.
// Synchronous reset clears all flags, counters and both output stages, and
// returns the configuration registers to their default values.
module stop_and_wait_retry_controller
  import swrc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  tick_t                  tick,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [15:0] ack_timeout_ticks;
  logic [3:0]  max_sends;
  logic [15:0] cooldown_ticks;
  logic [7:0]  debounce_ticks;

  logic                  waiting_flag, waiting_flag_next;
  logic                  cooling_flag, cooling_flag_next;
  logic [TIMER_BITS-1:0] cooldown_elapsed, cooldown_elapsed_next;
  logic [TIMER_BITS-1:0] since_send, since_send_next;
  logic [3:0]            sends_made, sends_made_next;
  logic                  debounce_active, debounce_active_next;
  logic [7:0]            debounce_left, debounce_left_next;

  result_t res_next;
  result_t skid;
  logic    skid_valid;
  logic    tick_fire;
  logic    result_fire;

  logic [7:0] left_dec;
  logic       skip;
  logic       confirm;

  assign tick_stall  = skid_valid;
  assign tick_fire   = tick_valid && !tick_stall;
  assign result_fire = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_ticks <= ACK_TIMEOUT_RESET;
      max_sends         <= MAX_SENDS_RESET;
      cooldown_ticks    <= COOLDOWN_RESET;
      debounce_ticks    <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACK_TIMEOUT: ack_timeout_ticks <= cfg_data;
        REG_MAX_SENDS:   max_sends         <= cfg_data[3:0];
        REG_COOLDOWN:    cooldown_ticks    <= cfg_data;
        REG_DEBOUNCE:    debounce_ticks    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cooldown_elapsed_next = (cooldown_elapsed == TIMER_MAX) ? TIMER_MAX :
                            cooldown_elapsed + 1'b1;
    since_send_next       = (since_send == TIMER_MAX) ? TIMER_MAX : since_send + 1'b1;
    waiting_flag_next     = waiting_flag;
    cooling_flag_next     = cooling_flag;
    sends_made_next       = sends_made;
    debounce_active_next  = debounce_active;
    debounce_left_next    = debounce_left;
    left_dec              = (debounce_left != 8'd0) ? debounce_left - 8'd1 : debounce_left;
    skip                  = 1'b0;
    confirm               = 1'b0;
    res_next              = '0;

    if (cooling_flag && (CMP_W'(cooldown_elapsed_next) >= CMP_W'(cooldown_ticks))) begin
      cooling_flag_next = 1'b0;
    end

    if (debounce_active) begin
      debounce_left_next = left_dec;
      if (left_dec == 8'd0) begin
        debounce_active_next = 1'b0;
        confirm              = tick.button_low;
      end else begin
        skip = 1'b1;
      end
    end else if (!cooling_flag_next && !waiting_flag && tick.button_low) begin
      if (debounce_ticks == 8'd0) begin
        confirm = 1'b1;
      end else begin
        debounce_active_next = 1'b1;
        debounce_left_next   = debounce_ticks;
        skip                 = 1'b1;
      end
    end

    if (confirm) begin
      sends_made_next       = 4'd1;
      since_send_next       = '0;
      waiting_flag_next     = 1'b1;
      res_next.send_pulse   = 1'b1;
      cooling_flag_next     = 1'b1;
      cooldown_elapsed_next = '0;
    end

    if (!skip) begin
      if (waiting_flag_next && tick.msg_valid && (tick.msg_head == ACK_WORD)) begin
        waiting_flag_next = 1'b0;
        sends_made_next   = 4'd0;
        res_next.ack_seen = 1'b1;
      end
      if (waiting_flag_next && (CMP_W'(since_send_next) > CMP_W'(ack_timeout_ticks))) begin
        if (sends_made_next < max_sends) begin
          since_send_next     = '0;
          sends_made_next     = sends_made_next + 4'd1;
          res_next.send_pulse = 1'b1;
        end else begin
          waiting_flag_next = 1'b0;
          res_next.gave_up  = 1'b1;
        end
      end
    end

    res_next.waiting    = waiting_flag_next;
    res_next.cooling    = cooling_flag_next;
    res_next.send_count = sends_made_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_flag     <= 1'b0;
      cooling_flag     <= 1'b0;
      cooldown_elapsed <= '0;
      since_send       <= '0;
      sends_made       <= 4'd0;
      debounce_active  <= 1'b0;
      debounce_left    <= 8'd0;
    end else if (tick_fire) begin
      waiting_flag     <= waiting_flag_next;
      cooling_flag     <= cooling_flag_next;
      cooldown_elapsed <= cooldown_elapsed_next;
      since_send       <= since_send_next;
      sends_made       <= sends_made_next;
      debounce_active  <= debounce_active_next;
      debounce_left    <= debounce_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_fire || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= tick_fire;
      end
    end else if (tick_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire || !result_valid) begin
      if (skid_valid) begin
        result <= skid;
      end else if (tick_fire) begin
        result <= res_next;
      end
    end else if (tick_fire) begin
      skid <= res_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("Skid stage holds a result while the result register is empty.");

  assert property (@(posedge clk) disable iff (rst)
    tick_fire |-> !(res_next.send_pulse && res_next.gave_up))
    else $error("A tick both sent and gave up.");

  assert property (@(posedge clk) disable iff (rst) debounce_active |-> !waiting_flag)
    else $error("Debounce wait is running while an acknowledgment is awaited.");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && !skid_valid && tick_fire) |=> skid_valid)
    else $error("A transfer arriving during a stall was not held in the skid stage.");

endmodule
